### rtl/wsfd_pkg.sv
// Shared types and constants for the WebSocket frame decoder.
package wsfd_pkg;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_PAYLOAD   = 2'd0;
  localparam kind_t KIND_EMPTY     = 2'd1;
  localparam kind_t KIND_MALFORMED = 2'd2;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [6:0] LEN_CTRL_MAX = 7'd125;
  localparam logic [6:0] LEN_EXT16    = 7'd126;
  localparam logic [6:0] LEN_EXT64    = 7'd127;

  localparam logic [3:0]  EXT16_BYTES = 4'd2;
  localparam logic [3:0]  EXT64_BYTES = 4'd8;
  localparam logic [2:0]  KEY_BYTES   = 3'd4;
  localparam logic [63:0] EXT16_MIN   = 64'd126;
  localparam logic [63:0] EXT64_MIN   = 64'h0000_0000_0001_0000;

  localparam logic [31:0] MAX_PAYLOAD_RST = 32'd65536;

endpackage

### rtl/websocket_frame_decoder.sv
// WebSocket frame decoder: header parse, length and mask key capture, payload unmasking.
//
// Input channel (in_valid/in_ready) carries one stream byte per word, with
// in_sync set to restart parsing at a frame header before that byte.
// Output channel (out_valid/out_ready) carries at most one result word per
// input word: an unmasked payload byte, an empty-frame marker or a
// malformed-frame report. Header, length and key bytes give no payload byte.
// The parser state is updated in the cycle a byte is accepted and the result
// is held in an output register, visible from the cycle after the byte is
// accepted; one byte is taken every cycle while the receiver keeps up.
// in_ready follows the output register: it is high when that register is
// empty or being read in the same cycle, so a stalled receiver holds the
// input after one pending result.
// After a malformed report the block drops bytes until a word with in_sync.
// Reset: parser back to the first header byte, max_payload to 65536, output
// register empty. cfg_we writes max_payload; write only while idle.
module websocket_frame_decoder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_sync,
  output logic                 out_valid,
  input  logic                 out_ready,
  output wsfd_pkg::kind_t      out_kind,
  output logic [7:0]           out_payload_byte,
  output logic [3:0]           out_frame_opcode,
  output logic                 out_final_flag,
  output logic                 out_was_masked,
  output logic [62:0]          out_frame_length,
  output logic                 out_last,
  input  logic                 cfg_we,
  input  logic [31:0]          cfg_wdata
);
  import wsfd_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_LEN,
    PH_KEY,
    PH_DATA
  } phase_t;

  phase_t      phase_r, phase_nxt, c_phase;
  logic [7:0]  fh_r, fh_nxt, c_fh;
  logic [3:0]  len_left_r, len_left_nxt, c_len_left;
  logic [63:0] len_acc_r, len_acc_nxt, c_len_acc;
  logic [31:0] key_r, key_nxt, c_key;
  logic [2:0]  key_left_r, key_left_nxt, c_key_left;
  logic [63:0] pay_idx_r, pay_idx_nxt, c_pay_idx;
  logic        halted_r, halted_nxt, c_halted;
  logic        masked_r, masked_nxt, c_masked;
  logic        wide_r, wide_nxt, c_wide;
  logic [31:0] max_payload_r;

  logic        out_valid_r;
  kind_t       out_kind_r;
  logic [7:0]  out_byte_r;
  logic [3:0]  out_op_r;
  logic        out_fin_r;
  logic        out_masked_r;
  logic [62:0] out_len_r;
  logic        out_last_r;

  logic        in_acc;
  logic        res_valid;
  kind_t       res_kind;
  logic [7:0]  res_byte;
  logic        res_last;
  logic        mal;
  logic        len_done;
  logic        start_pay;
  logic [3:0]  op;
  logic [6:0]  short_len;
  logic [63:0] len_shift;
  logic [3:0]  len_left_dec;
  logic [2:0]  key_left_dec;
  logic [63:0] idx_inc;
  logic [7:0]  key_byte;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    if (in_sync) begin
      c_phase    = PH_HDR0;
      c_fh       = '0;
      c_len_left = '0;
      c_len_acc  = '0;
      c_key      = '0;
      c_key_left = '0;
      c_pay_idx  = '0;
      c_halted   = 1'b0;
      c_masked   = 1'b0;
      c_wide     = 1'b0;
    end else begin
      c_phase    = phase_r;
      c_fh       = fh_r;
      c_len_left = len_left_r;
      c_len_acc  = len_acc_r;
      c_key      = key_r;
      c_key_left = key_left_r;
      c_pay_idx  = pay_idx_r;
      c_halted   = halted_r;
      c_masked   = masked_r;
      c_wide     = wide_r;
    end

    phase_nxt    = c_phase;
    fh_nxt       = c_fh;
    len_left_nxt = c_len_left;
    len_acc_nxt  = c_len_acc;
    key_nxt      = c_key;
    key_left_nxt = c_key_left;
    pay_idx_nxt  = c_pay_idx;
    halted_nxt   = c_halted;
    masked_nxt   = c_masked;
    wide_nxt     = c_wide;

    res_valid = 1'b0;
    res_kind  = KIND_PAYLOAD;
    res_byte  = '0;
    res_last  = 1'b0;
    mal       = 1'b0;
    len_done  = 1'b0;
    start_pay = 1'b0;

    op           = c_fh[3:0];
    short_len    = in_data_byte[6:0];
    len_shift    = {c_len_acc[55:0], in_data_byte};
    len_left_dec = c_len_left - 4'd1;
    key_left_dec = c_key_left - 3'd1;
    idx_inc      = c_pay_idx + 64'd1;
    case (c_pay_idx[1:0])
      2'd0:    key_byte = c_key[31:24];
      2'd1:    key_byte = c_key[23:16];
      2'd2:    key_byte = c_key[15:8];
      default: key_byte = c_key[7:0];
    endcase

    if (!c_halted) begin
      case (c_phase)
        PH_HDR0: begin
          fh_nxt    = in_data_byte;
          phase_nxt = PH_HDR1;
        end
        PH_HDR1: begin
          masked_nxt = in_data_byte[7];
          key_nxt    = '0;
          if (c_fh[6:4] != 3'd0 ||
              !(op inside {OP_CONT, OP_TEXT, OP_BIN, OP_CLOSE, OP_PING, OP_PONG})) begin
            mal = 1'b1;
          end else if (op[3] && (short_len > LEN_CTRL_MAX || !c_fh[7])) begin
            mal = 1'b1;
          end else if (short_len == LEN_EXT16) begin
            len_acc_nxt  = '0;
            wide_nxt     = 1'b0;
            len_left_nxt = EXT16_BYTES;
            phase_nxt    = PH_LEN;
          end else if (short_len == LEN_EXT64) begin
            len_acc_nxt  = '0;
            wide_nxt     = 1'b1;
            len_left_nxt = EXT64_BYTES;
            phase_nxt    = PH_LEN;
          end else begin
            len_acc_nxt = {57'd0, short_len};
            len_done    = 1'b1;
          end
        end
        PH_LEN: begin
          len_acc_nxt  = len_shift;
          len_left_nxt = len_left_dec;
          if (len_left_dec == 4'd0) begin
            if (!c_wide) begin
              if (len_shift < EXT16_MIN) mal = 1'b1;
              else len_done = 1'b1;
            end else begin
              if (len_shift[63] || len_shift < EXT64_MIN) mal = 1'b1;
              else len_done = 1'b1;
            end
          end
        end
        PH_KEY: begin
          key_nxt      = {c_key[23:0], in_data_byte};
          key_left_nxt = key_left_dec;
          if (key_left_dec == 3'd0) start_pay = 1'b1;
        end
        PH_DATA: begin
          pay_idx_nxt = idx_inc;
          res_valid   = 1'b1;
          res_kind    = KIND_PAYLOAD;
          res_byte    = in_data_byte ^ (c_masked ? key_byte : 8'd0);
          res_last    = (idx_inc >= c_len_acc);
          if (res_last) phase_nxt = PH_HDR0;
        end
        default: begin
          phase_nxt    = PH_HDR0;
          fh_nxt       = '0;
          len_left_nxt = '0;
          len_acc_nxt  = '0;
          key_nxt      = '0;
          key_left_nxt = '0;
          pay_idx_nxt  = '0;
          halted_nxt   = 1'b0;
          masked_nxt   = 1'b0;
          wide_nxt     = 1'b0;
        end
      endcase
    end

    if (len_done) begin
      if (len_acc_nxt > {32'd0, max_payload_r}) begin
        mal = 1'b1;
      end else if (masked_nxt) begin
        key_nxt      = '0;
        key_left_nxt = KEY_BYTES;
        phase_nxt    = PH_KEY;
      end else begin
        start_pay = 1'b1;
      end
    end

    if (start_pay) begin
      pay_idx_nxt = '0;
      if (len_acc_nxt == 64'd0) begin
        res_valid = 1'b1;
        res_kind  = KIND_EMPTY;
        res_last  = 1'b1;
        phase_nxt = PH_HDR0;
      end else begin
        phase_nxt = PH_DATA;
      end
    end

    if (mal) begin
      phase_nxt    = PH_HDR0;
      fh_nxt       = '0;
      len_left_nxt = '0;
      len_acc_nxt  = '0;
      key_nxt      = '0;
      key_left_nxt = '0;
      pay_idx_nxt  = '0;
      halted_nxt   = 1'b1;
      masked_nxt   = 1'b0;
      wide_nxt     = 1'b0;
      res_valid    = 1'b1;
      res_kind     = KIND_MALFORMED;
      res_byte     = '0;
      res_last     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HDR0;
      fh_r          <= '0;
      len_left_r    <= '0;
      len_acc_r     <= '0;
      key_r         <= '0;
      key_left_r    <= '0;
      pay_idx_r     <= '0;
      halted_r      <= 1'b0;
      masked_r      <= 1'b0;
      wide_r        <= 1'b0;
      max_payload_r <= MAX_PAYLOAD_RST;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) max_payload_r <= cfg_wdata;
      if (in_acc) begin
        phase_r     <= phase_nxt;
        fh_r        <= fh_nxt;
        len_left_r  <= len_left_nxt;
        len_acc_r   <= len_acc_nxt;
        key_r       <= key_nxt;
        key_left_r  <= key_left_nxt;
        pay_idx_r   <= pay_idx_nxt;
        halted_r    <= halted_nxt;
        masked_r    <= masked_nxt;
        wide_r      <= wide_nxt;
        out_valid_r <= res_valid;
        if (res_valid) begin
          out_kind_r <= res_kind;
          out_byte_r <= res_byte;
          out_last_r <= res_last;
          if (res_kind == KIND_MALFORMED) begin
            out_op_r     <= '0;
            out_fin_r    <= 1'b0;
            out_masked_r <= 1'b0;
            out_len_r    <= '0;
          end else begin
            out_op_r     <= fh_nxt[3:0];
            out_fin_r    <= fh_nxt[7];
            out_masked_r <= masked_nxt;
            out_len_r    <= len_acc_nxt[62:0];
          end
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_payload_byte = out_byte_r;
  assign out_frame_opcode = out_op_r;
  assign out_final_flag   = out_fin_r;
  assign out_was_masked   = out_masked_r;
  assign out_frame_length = out_len_r;
  assign out_last         = out_last_r;

`ifndef SYNTHESIS
  a_mal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_MALFORMED |->
      out_payload_byte == 8'd0 && out_frame_length == 63'd0 && !out_last)
    else $error("malformed word carries nonzero fields");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_EMPTY |->
      out_last && out_payload_byte == 8'd0 && out_frame_length == 63'd0)
    else $error("empty-frame word malformed");

  a_halt_after_mal: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && res_valid && res_kind == KIND_MALFORMED |=> halted_r)
    else $error("parser not halted after malformed frame");

  a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && halted_r && !in_sync |=> !out_valid_r && halted_r)
    else $error("result produced while halted");
`endif

endmodule

### verif/tb_websocket_frame_decoder.sv
// Testbench for the WebSocket frame decoder: byte stream stimulus, result prediction and checks.
`timescale 1ns / 1ps

module tb_websocket_frame_decoder;
  import wsfd_pkg::*;

  localparam int STALL_LIMIT = 2000;

  typedef enum logic [2:0] {
    HUNT_HDR0,
    HUNT_HDR1,
    TAKE_LEN,
    TAKE_KEY,
    TAKE_DATA
  } parse_phase_t;

  typedef enum int {
    FORM_SHORT,
    FORM_EXT16,
    FORM_EXT64
  } len_form_t;

  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_QUARTER,
    RX_TRICKLE
  } rx_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       sync;
  } stream_word_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [3:0]  opcode;
    logic        fin;
    logic        masked;
    logic [62:0] length;
    logic        last;
  } ws_word_t;

  class frame_decode_scoreboard;
    logic [31:0]  max_payload;
    parse_phase_t phase;
    logic [7:0]   hdr0;
    logic [3:0]   len_left;
    logic [63:0]  len_acc;
    logic [31:0]  key;
    logic [2:0]   key_left;
    logic [63:0]  byte_idx;
    logic         halted;
    logic         masked;
    logic         wide;
    ws_word_t     expected_words[$];
    int           fails;

    function new();
      max_payload = MAX_PAYLOAD_RST;
      fails = 0;
      restart();
    endfunction

    function void restart();
      phase = HUNT_HDR0;
      hdr0 = '0;
      len_left = '0;
      len_acc = '0;
      key = '0;
      key_left = '0;
      byte_idx = '0;
      halted = 1'b0;
      masked = 1'b0;
      wide = 1'b0;
    endfunction

    function void push_word(kind_t kind, logic [7:0] pbyte, logic last);
      ws_word_t w;
      w.kind = kind;
      w.payload_byte = pbyte;
      w.opcode = hdr0[3:0];
      w.fin = hdr0[7];
      w.masked = masked;
      w.length = len_acc[62:0];
      w.last = last;
      expected_words.insert(expected_words.size(), w);
    endfunction

    function void malformed();
      ws_word_t w;
      w = '0;
      w.kind = KIND_MALFORMED;
      expected_words.insert(expected_words.size(), w);
      restart();
      halted = 1'b1;
    endfunction

    function void begin_payload();
      byte_idx = '0;
      if (len_acc == 64'd0) begin
        push_word(KIND_EMPTY, 8'd0, 1'b1);
        phase = HUNT_HDR0;
      end else begin
        phase = TAKE_DATA;
      end
    endfunction

    function void length_complete();
      if (len_acc > {32'd0, max_payload}) begin
        malformed();
      end else if (masked) begin
        key = '0;
        key_left = KEY_BYTES;
        phase = TAKE_KEY;
      end else begin
        begin_payload();
      end
    endfunction

    function void note_byte(logic [7:0] b, logic s);
      logic [3:0] op;
      logic [6:0] short_len;
      logic [4:0] shift;
      logic [7:0] key_byte;
      logic       last;
      if (s) restart();
      if (halted) return;
      case (phase)
        HUNT_HDR0: begin
          hdr0 = b;
          phase = HUNT_HDR1;
        end
        HUNT_HDR1: begin
          op = hdr0[3:0];
          short_len = b[6:0];
          masked = b[7];
          key = '0;
          if (hdr0[6:4] != 3'b000 ||
              !(op inside {OP_CONT, OP_TEXT, OP_BIN, OP_CLOSE, OP_PING, OP_PONG})) begin
            malformed();
          end else if (op[3] && (short_len > LEN_CTRL_MAX || !hdr0[7])) begin
            malformed();
          end else begin
            len_acc = '0;
            if (short_len == LEN_EXT16) begin
              wide = 1'b0;
              len_left = EXT16_BYTES;
              phase = TAKE_LEN;
            end else if (short_len == LEN_EXT64) begin
              wide = 1'b1;
              len_left = EXT64_BYTES;
              phase = TAKE_LEN;
            end else begin
              len_acc = {57'd0, short_len};
              length_complete();
            end
          end
        end
        TAKE_LEN: begin
          len_acc = {len_acc[55:0], b};
          len_left = len_left - 4'd1;
          if (len_left == 4'd0) begin
            if (!wide && len_acc < EXT16_MIN) begin
              malformed();
            end else if (wide && (len_acc[63] || len_acc < EXT64_MIN)) begin
              malformed();
            end else begin
              length_complete();
            end
          end
        end
        TAKE_KEY: begin
          key = {key[23:0], b};
          key_left = key_left - 3'd1;
          if (key_left == 3'd0) begin_payload();
        end
        TAKE_DATA: begin
          shift = 5'd24 - {byte_idx[1:0], 3'b000};
          key_byte = masked ? key[shift +: 8] : 8'd0;
          byte_idx = byte_idx + 64'd1;
          last = (byte_idx >= len_acc);
          push_word(KIND_PAYLOAD, b ^ key_byte, last);
          if (last) phase = HUNT_HDR0;
        end
        default: restart();
      endcase
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        fails++;
      end
    endfunction

    function void check_word(ws_word_t got);
      ws_word_t want;
      if (expected_words.size() == 0) begin
        $error("result word with none expected (kind %0d)", got.kind);
        fails++;
        return;
      end
      want = expected_words.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("payload_byte", want.payload_byte, got.payload_byte);
      compare_field("frame_opcode", want.opcode, got.opcode);
      compare_field("final_flag", want.fin, got.fin);
      compare_field("was_masked", want.masked, got.masked);
      compare_field("frame_length", want.length, got.length);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_sync = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  kind_t       out_kind;
  logic [7:0]  out_payload_byte;
  logic [3:0]  out_frame_opcode;
  logic        out_final_flag;
  logic        out_was_masked;
  logic [62:0] out_frame_length;
  logic        out_last;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = 32'd0;

  frame_decode_scoreboard sb;
  stream_word_t           stim_q[$];
  logic                   resync_next = 1'b0;
  int                     idle_cycles = 0;
  rx_mode_t               rx_mode = RX_ALWAYS;
  int                     rx_span = 0;
  logic [4:0]             rx_tick = 5'd0;
  logic [31:0]            max_settings [6];

  websocket_frame_decoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_sync         (in_sync),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_payload_byte(out_payload_byte),
    .out_frame_opcode(out_frame_opcode),
    .out_final_flag  (out_final_flag),
    .out_was_masked  (out_was_masked),
    .out_frame_length(out_frame_length),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  always #5 clk = ~clk;

  // receiver stall pattern, mode changes every so often
  always @(negedge clk) begin
    rx_tick <= rx_tick + 5'd1;
    if (rx_span == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_span <= $urandom_range(20, 200);
    end else begin
      rx_span <= rx_span - 1;
    end
    case (rx_mode)
      RX_ALWAYS:  out_ready <= 1'b1;
      RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
      RX_QUARTER: out_ready <= (rx_tick[1:0] == 2'd0);
      default:    out_ready <= (rx_tick == 5'd31);
    endcase
  end

  always @(posedge clk) begin : monitor
    ws_word_t got;
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_byte(in_data_byte, in_sync);
      if (out_valid && out_ready) begin
        got.kind = out_kind;
        got.payload_byte = out_payload_byte;
        got.opcode = out_frame_opcode;
        got.fin = out_final_flag;
        got.masked = out_was_masked;
        got.length = out_frame_length;
        got.last = out_last;
        sb.check_word(got);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[websocket_frame_decoder] ERROR");
      $finish;
    end
  end

  function automatic logic [3:0] opcode_at(int i);
    case (i)
      0:       return OP_CONT;
      1:       return OP_TEXT;
      2:       return OP_BIN;
      3:       return OP_CLOSE;
      4:       return OP_PING;
      default: return OP_PONG;
    endcase
  endfunction

  task automatic put(input logic [7:0] b, input logic s);
    stream_word_t w;
    w.data = b;
    w.sync = s;
    stim_q.insert(stim_q.size(), w);
  endtask

  task automatic put_body(input int n);
    repeat (n) put(8'($urandom), 1'b0);
  endtask

  task automatic put_header(input logic [7:0] h0, input logic mask, input logic [63:0] len,
                            input len_form_t form, input logic s);
    put(h0, s);
    case (form)
      FORM_SHORT: put({mask, len[6:0]}, 1'b0);
      FORM_EXT16: begin
        put({mask, LEN_EXT16}, 1'b0);
        put(len[15:8], 1'b0);
        put(len[7:0], 1'b0);
      end
      default: begin
        put({mask, LEN_EXT64}, 1'b0);
        for (int i = 7; i >= 0; i--) put(len[8*i +: 8], 1'b0);
      end
    endcase
    if (mask) put_body(4);
  endtask

  task automatic queue_directed();
    put(8'h81, 1'b1); put(8'h01, 1'b0); put(8'hA5, 1'b0);
    put(8'h02, 1'b0); put(8'h83, 1'b0);
    put(8'hFF, 1'b0); put(8'h00, 1'b0); put(8'hAA, 1'b0); put(8'h55, 1'b0);
    put(8'h00, 1'b0); put(8'hFF, 1'b0); put(8'h5A, 1'b0);
    put(8'h89, 1'b0); put(8'h00, 1'b0);
    put(8'h8A, 1'b0); put(8'h80, 1'b0);
    put(8'h12, 1'b0); put(8'h34, 1'b0); put(8'h56, 1'b0); put(8'h78, 1'b0);
    // reserved bits set, then a swallowed byte, then a long close frame
    put(8'hF0, 1'b0); put(8'h7F, 1'b0);
    put(8'h00, 1'b0);
    put(8'h88, 1'b1); put(8'h7E, 1'b0);
    resync_next = 1'b1;
  endtask

  task automatic build_random(input int budget);
    int          base;
    int          pick;
    logic        s;
    logic        fin;
    logic        mask;
    logic [3:0]  op;
    logic [63:0] len;
    len_form_t   form;
    base = stim_q.size();
    while (stim_q.size() - base < budget) begin
      pick = $urandom_range(0, 99);
      s = resync_next || ($urandom_range(0, 3) == 0);
      resync_next = 1'b0;
      mask = 1'($urandom_range(0, 1));
      fin = 1'($urandom_range(0, 1));
      op = opcode_at($urandom_range(0, 5));
      if (op[3]) fin = 1'b1;
      if (pick < 50) begin
        len = ($urandom_range(0, 3) == 0) ? 64'd0 : 64'($urandom_range(1, 10));
        put_header({fin, 3'b000, op}, mask, len, FORM_SHORT, s);
        put_body(int'(len));
        resync_next = (len > {32'd0, sb.max_payload});
      end else if (pick < 58) begin
        op = opcode_at($urandom_range(0, 2));
        len = 64'($urandom_range(126, 140));
        put_header({fin, 3'b000, op}, mask, len, FORM_EXT16, s);
        put_body(int'(len));
        resync_next = (len > {32'd0, sb.max_payload});
      end else if (pick < 62) begin
        // long frame, cut short by a sync
        op = opcode_at($urandom_range(0, 2));
        len = {32'd0, $urandom} | EXT64_MIN;
        put_header({fin, 3'b000, op}, mask, len, FORM_EXT64, s);
        put_body($urandom_range(1, 6));
        resync_next = 1'b1;
      end else if (pick < 66) begin
        len = 64'($urandom_range(3, 10));
        put_header({fin, 3'b000, op}, mask, len, FORM_SHORT, s);
        put_body($urandom_range(0, int'(len) - 1));
        resync_next = 1'b1;
      end else if (pick < 90) begin
        case ($urandom_range(0, 7))
          0: begin
            put({fin, 3'($urandom_range(1, 7)), op}, s);
            put(8'($urandom), 1'b0);
          end
          1: begin
            op = $urandom_range(0, 1) ? 4'($urandom_range(3, 7)) : 4'($urandom_range(11, 15));
            put({fin, 3'b000, op}, s);
            put(8'($urandom), 1'b0);
          end
          2: begin
            put({1'b0, 3'b000, opcode_at($urandom_range(3, 5))}, s);
            put({mask, 7'($urandom_range(0, 125))}, 1'b0);
          end
          3: begin
            put({1'b1, 3'b000, opcode_at($urandom_range(3, 5))}, s);
            put({mask, $urandom_range(0, 1) ? LEN_EXT16 : LEN_EXT64}, 1'b0);
          end
          4: begin
            put_header({fin, 3'b000, opcode_at($urandom_range(0, 2))}, mask,
                       64'($urandom_range(0, 125)), FORM_EXT16, s);
          end
          5: begin
            put_header({fin, 3'b000, opcode_at($urandom_range(0, 2))}, mask,
                       {1'b1, 31'($urandom), $urandom}, FORM_EXT64, s);
          end
          6: begin
            put_header({fin, 3'b000, opcode_at($urandom_range(0, 2))}, mask,
                       64'($urandom_range(0, 65535)), FORM_EXT64, s);
          end
          default: begin
            len = {32'd0, sb.max_payload} + 64'd1;
            if (len < EXT16_MIN) form = FORM_SHORT;
            else if (len < EXT64_MIN) form = FORM_EXT16;
            else form = FORM_EXT64;
            put_header({fin, 3'b000, opcode_at($urandom_range(0, 2))}, mask, len, form, s);
          end
        endcase
        put_body($urandom_range(0, 3));
        resync_next = 1'b1;
      end else begin
        repeat ($urandom_range(1, 4)) put(8'($urandom), ($urandom_range(0, 3) == 0));
        resync_next = 1'b1;
      end
    end
  endtask

  task automatic drive_stream();
    stream_word_t w;
    int           burst_left;
    burst_left = $urandom_range(1, 12);
    while (stim_q.size() != 0) begin
      w = stim_q.pop_front();
      in_valid <= 1'b1;
      in_data_byte <= w.data;
      in_sync <= w.sync;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      @(negedge clk);
      burst_left--;
      if (stim_q.size() == 0 || burst_left == 0) begin
        in_valid <= 1'b0;
        if (burst_left == 0) begin
          repeat (($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3))
            @(negedge clk);
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                   : $urandom_range(1, 12);
        end
      end
    end
  endtask

  task automatic wait_drained(input int extra);
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_max_payload(input logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.max_payload = v;
  endtask

  initial begin
    sb = new();
    max_settings = '{32'hFFFF_FFFF, 32'd0, 32'd126, 32'd9, 32'd65535, 32'd0};
    max_settings[5] = $urandom_range(5, 300);
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    queue_directed();
    build_random(30);
    drive_stream();
    foreach (max_settings[i]) begin
      wait_drained(4);
      write_max_payload(max_settings[i]);
      build_random(30);
      drive_stream();
    end
    wait_drained(10);
    if (sb.fails == 0 && sb.expected_words.size() == 0) begin
      $display("[websocket_frame_decoder] OK");
    end else begin
      $display("[websocket_frame_decoder] ERROR");
    end
    $finish;
  end

endmodule
